// ===== rtl/sipmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipmt_pkg: shared types and constants for the source address TTL table
// Field widths of the item ports and the layout of one table row.
// ----------------------------------------------------------------------------
package sipmt_pkg;

    localparam int ADDR_W        = 32;
    localparam int HOP_W         = 8;
    localparam int INDEX_W       = 6;
    localparam int TABLE_ENTRIES_DEF = 64;

    // one table row: source address, test address, largest TTL seen
    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] tst;
        logic [HOP_W-1:0]  hop;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== rtl/sipmt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipmt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sipmt_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/source_ip_max_ttl_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_ip_max_ttl_table_core: table of distinct source addresses with
// the largest TTL seen for each
// Looks up each item by source address, raises the stored TTL on a hit,
// appends a new row on a miss while room is left.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries source address, test
//   address and TTL. Output channel o_out_valid / i_out_ready carries one
//   result per item: was_new, entry index, stored TTL, stored test address
//   and table_full.
//   One item is worked at a time. The table RAM is scanned one row per cycle
//   with the address compare pipelined behind the registered read, so a
//   miss reads every used row and a hit stops at the first matching row;
//   the single RAM read port sets the scan speed.
//   The result waits in an output register; a new item is accepted while it
//   waits, but a finished item holds in its result state until the output
//   register is free, so a stalled receiver stalls the block after one item.
//   Reset empties the table at once (row count to zero); row contents are
//   not cleared since only rows below the count are ever read.
// ----------------------------------------------------------------------------
module source_ip_max_ttl_table_core #(
    parameter int TABLE_ENTRIES = sipmt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sipmt_pkg::ADDR_W-1:0]  i_source_address,
    input  logic [sipmt_pkg::ADDR_W-1:0]  i_test_address,
    input  logic [sipmt_pkg::HOP_W-1:0]   i_hop_limit,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_was_new,
    output logic [sipmt_pkg::INDEX_W-1:0] o_entry_index,
    output logic [sipmt_pkg::HOP_W-1:0]   o_stored_hop_limit,
    output logic [sipmt_pkg::ADDR_W-1:0]  o_stored_test_address,
    output logic                          o_table_full
);

    import sipmt_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW:0] ENTRIES_C = (AW+1)'(TABLE_ENTRIES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    // control
    logic [1:0]  r_state, n_state;
    logic [AW:0] r_used, n_used;
    logic [AW:0] r_rd_idx, n_rd_idx;
    logic        r_pend, n_pend;
    logic        r_out_valid, n_out_valid;

    // payload
    logic [AW-1:0]     r_cmp_idx;
    logic [ADDR_W-1:0] r_src, r_tst;
    logic [HOP_W-1:0]  r_hop;
    logic              r_res_new, r_res_full;
    logic [AW-1:0]     r_res_idx;
    logic [HOP_W-1:0]  r_res_hop;
    logic [ADDR_W-1:0] r_res_tst;
    logic              r_o_new, r_o_full;
    logic [INDEX_W-1:0] r_o_idx;
    logic [HOP_W-1:0]  r_o_hop;
    logic [ADDR_W-1:0] r_o_tst;

    logic              in_acc, out_free, load_out;
    logic              rd_en, hit, miss, full, append;
    logic [ENTRY_W-1:0] rd_data;
    t_entry            rd_entry, wr_entry;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [HOP_W-1:0]  max_hop;
    logic [AW+INDEX_W-1:0] idx_ext;

    sipmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        in_acc   = i_in_valid && o_in_ready;
        out_free = !r_out_valid || i_out_ready;
        load_out = (r_state == ST_RESULT) && out_free;

        rd_entry = t_entry'(rd_data);
        rd_en    = (r_state == ST_SCAN) && (r_rd_idx < r_used);
        hit      = (r_state == ST_SCAN) && r_pend && (rd_entry.src == r_src);
        // scan drained with no match
        miss     = (r_state == ST_SCAN) && !r_pend && !rd_en;
        full     = (r_used == ENTRIES_C);
        append   = miss && !full;
        max_hop  = (r_hop > rd_entry.hop) ? r_hop : rd_entry.hop;

        wr_en    = (hit && (r_hop > rd_entry.hop)) || append;
        wr_addr  = hit ? r_cmp_idx : r_used[AW-1:0];
        wr_entry.src = r_src;
        wr_entry.tst = hit ? rd_entry.tst : r_tst;
        wr_entry.hop = r_hop;

        idx_ext  = {{INDEX_W{1'b0}}, r_res_idx};
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state  = ST_SCAN;
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                end
            end
            ST_SCAN: begin
                n_pend = rd_en;
                if (rd_en) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (hit || miss) begin
                    n_state = ST_RESULT;
                end
                if (append) begin
                    n_used = r_used + 1'b1;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_src <= i_source_address;
            r_tst <= i_test_address;
            r_hop <= i_hop_limit;
        end
        // track which row the registered read data belongs to
        r_cmp_idx <= r_rd_idx[AW-1:0];
        if (hit) begin
            r_res_new  <= 1'b0;
            r_res_full <= 1'b0;
            r_res_idx  <= r_cmp_idx;
            r_res_hop  <= max_hop;
            r_res_tst  <= rd_entry.tst;
        end else if (miss) begin
            r_res_new  <= !full;
            r_res_full <= full;
            r_res_idx  <= full ? '0 : r_used[AW-1:0];
            r_res_hop  <= full ? '0 : r_hop;
            r_res_tst  <= full ? '0 : r_tst;
        end
        if (load_out) begin
            r_o_new  <= r_res_new;
            r_o_full <= r_res_full;
            r_o_idx  <= idx_ext[INDEX_W-1:0];
            r_o_hop  <= r_res_hop;
            r_o_tst  <= r_res_tst;
        end
    end

    assign o_in_ready            = (r_state == ST_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_was_new             = r_o_new;
    assign o_entry_index         = r_o_idx;
    assign o_stored_hop_limit    = r_o_hop;
    assign o_stored_test_address = r_o_tst;
    assign o_table_full          = r_o_full;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= ENTRIES_C)
        else $error("row count beyond table size");

    a_used_only_on_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != $past(r_used)) |-> ($past(append) && $past(i_rst_n)))
        else $error("row count moved without an appended row");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_full) |-> (!o_was_new && o_entry_index == '0))
        else $error("full result carries a row");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_SCAN))
        else $error("accepted item did not start a scan");

endmodule

// ===== tb/sv/ttl_table_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_table_check_pkg: expected-result tracking for the source TTL table
// Keeps its own copy of the table and predicts the result of every accepted
// item. Results from the block are checked in order against that prediction.
// ----------------------------------------------------------------------------
package ttl_table_check_pkg;

    import sipmt_pkg::*;

    typedef struct packed {
        logic               was_new;
        logic [INDEX_W-1:0] entry_index;
        logic [HOP_W-1:0]   hop;
        logic [ADDR_W-1:0]  tst;
        logic               full;
    } t_ttl_result;

    class ttl_table_tracker;

        logic [ADDR_W-1:0] src_rows [TABLE_ENTRIES_DEF];
        logic [ADDR_W-1:0] tst_rows [TABLE_ENTRIES_DEF];
        logic [HOP_W-1:0]  hop_rows [TABLE_ENTRIES_DEF];
        int                rows_used;
        t_ttl_result       expected_results [$];
        int                mismatch_count;

        function new();
            rows_used      = 0;
            mismatch_count = 0;
        endfunction

        // Work out the result of one accepted item and queue it.
        function void note_record(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] tst,
                                  logic [HOP_W-1:0] hop);
            t_ttl_result r;
            int          row;
            int          hit_row;
            r       = '0;
            hit_row = -1;
            for (row = 0; row < rows_used && hit_row < 0; row++) begin
                if (src_rows[row] == src) begin
                    hit_row = row;
                end
            end
            if (hit_row >= 0) begin
                if (hop > hop_rows[hit_row]) begin
                    hop_rows[hit_row] = hop;
                end
                r.entry_index = hit_row[INDEX_W-1:0];
                r.hop         = hop_rows[hit_row];
                r.tst         = tst_rows[hit_row];
            end else if (rows_used >= TABLE_ENTRIES_DEF) begin
                // table full: nothing stored, all other fields stay zero
                r.full = 1'b1;
            end else begin
                src_rows[rows_used] = src;
                tst_rows[rows_used] = tst;
                hop_rows[rows_used] = hop;
                r.was_new           = 1'b1;
                r.entry_index       = rows_used[INDEX_W-1:0];
                r.hop               = hop;
                r.tst               = tst;
                rows_used++;
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(t_ttl_result got);
            t_ttl_result exp;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                mismatch_count++;
                return;
            end
            exp = expected_results.pop_front();
            if (got.was_new !== exp.was_new) begin
                $display("%0t: was_new expected %b actual %b", $time, exp.was_new,
                         got.was_new);
                mismatch_count++;
            end
            if (got.entry_index !== exp.entry_index) begin
                $display("%0t: entry_index expected %0d actual %0d", $time,
                         exp.entry_index, got.entry_index);
                mismatch_count++;
            end
            if (got.hop !== exp.hop) begin
                $display("%0t: stored_hop_limit expected %0d actual %0d", $time, exp.hop,
                         got.hop);
                mismatch_count++;
            end
            if (got.tst !== exp.tst) begin
                $display("%0t: stored_test_address expected %h actual %h", $time, exp.tst,
                         got.tst);
                mismatch_count++;
            end
            if (got.full !== exp.full) begin
                $display("%0t: table_full expected %b actual %b", $time, exp.full,
                         got.full);
                mismatch_count++;
            end
        endfunction

    endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: source address TTL table
// Directed items cover address and TTL extremes, hits, ties and near-miss
// addresses; random items mostly revisit known sources while new ones fill
// the table past full. Both sides idle at random, with a steady stretch and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import sipmt_pkg::*;
    import ttl_table_check_pkg::*;

    localparam int IDLE_PCT       = 27;
    localparam int RANDOM_ITEMS   = 500;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int TAIL_CYCLES    = 80;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [ADDR_W-1:0]  i_source_address;
    logic [ADDR_W-1:0]  i_test_address;
    logic [HOP_W-1:0]   i_hop_limit;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_was_new;
    logic [INDEX_W-1:0] o_entry_index;
    logic [HOP_W-1:0]   o_stored_hop_limit;
    logic [ADDR_W-1:0]  o_stored_test_address;
    logic               o_table_full;

    logic holdoff_go = 1'b0;
    logic rx_steady  = 1'b0;
    bit   tx_steady  = 1'b0;

    ttl_table_tracker table_model = new();

    source_ip_max_ttl_table_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES_DEF)
    ) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_source_address      (i_source_address),
        .i_test_address        (i_test_address),
        .i_hop_limit           (i_hop_limit),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_was_new             (o_was_new),
        .o_entry_index         (o_entry_index),
        .o_stored_hop_limit    (o_stored_hop_limit),
        .o_stored_test_address (o_stored_test_address),
        .o_table_full          (o_table_full)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Note accepted items before checking results taken on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            table_model.note_record(i_source_address, i_test_address, i_hop_limit);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            table_model.check_result({o_was_new, o_entry_index, o_stored_hop_limit,
                                      o_stored_test_address, o_table_full});
        end
    end

    initial begin : receiver
        bit held_off;
        held_off = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_go && !held_off) begin
                // stall the output so the block backs up into its input
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= rx_steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_item(input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] tst,
                             input logic [HOP_W-1:0] hop);
        if (!tx_steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid       <= 1'b1;
        i_source_address <= src;
        i_test_address   <= tst;
        i_hop_limit      <= hop;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic logic [HOP_W-1:0] pick_hop();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return HOP_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly revisit a known source; otherwise a fresh or one-bit-off address.
    function automatic logic [ADDR_W-1:0] pick_source();
        logic [ADDR_W-1:0] known;
        known = table_model.src_rows[$urandom_range(0, table_model.rows_used - 1)];
        if ($urandom_range(0, 5) != 0) begin
            return known;
        end
        if ($urandom_range(0, 1) == 0) begin
            return $urandom();
        end
        return known ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1));
    endfunction

    initial begin : stimulus
        int n;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_source_address <= '0;
        i_test_address   <= '0;
        i_hop_limit      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, hits, ties and near misses
        send_item(32'h0000_0000, 32'hFFFF_FFFF, 8'd0);
        send_item(32'hFFFF_FFFF, 32'h0000_0000, 8'd255);
        send_item(32'h0000_0000, 32'h1234_5678, 8'd0);
        send_item(32'h0000_0000, 32'h0000_0000, 8'd255);
        send_item(32'h0000_0000, 32'hFFFF_FFFF, 8'd1);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
        send_item(32'hFFFF_FFFE, 32'hA5A5_A5A5, 8'd17);
        send_item(32'h7FFF_FFFF, 32'h5A5A_5A5A, 8'd128);
        send_item(32'h0000_0001, 32'h8000_0000, 8'd127);
        send_item(32'hFFFF_FFFF, 32'h0000_0001, 8'd255);
        send_item(32'h7FFF_FFFF, 32'h0000_0000, 8'd200);
        send_item(32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'h55);
        send_item(32'hA5A5_A5A5, 32'hFFFF_FFFF, 8'hAA);
        send_item(32'h5A5A_5A5A, 32'hA5A5_A5A5, 8'hAA);
        send_item(32'h5A5A_5A5A, 32'h0000_0000, 8'h55);
        send_item(32'h0000_0001, 32'h1111_1111, 8'd128);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 60) begin
                holdoff_go <= 1'b1;
            end
            if (n == 150) begin
                tx_steady = 1'b1;
                rx_steady <= 1'b1;
            end
            if (n == 300) begin
                tx_steady = 1'b0;
                rx_steady <= 1'b0;
            end
            send_item(pick_source(), $urandom(), pick_hop());
        end
        i_in_valid <= 1'b0;

        while (table_model.expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (table_model.mismatch_count == 0 && table_model.expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
